@@ hdl/rsh_pkg.sv @@
package rsh_pkg;

   // Width of a carry-state count; counts wrap modulo 2^COUNT_W.
   localparam int COUNT_W = 33;
   // Width of the difference fields on the request port.
   localparam int DIFF_BITS = 16;
   localparam int DIFF_IDX_W = 4;
   // Width of the shift amount field.
   localparam int SHIFT_W = 4;
   // Wide enough for a bit position plus a shift amount.
   localparam int SEL_W = 6;
   // Number of carry states in one vector and the index of the last one.
   localparam int NUM_STATES = 8;
   localparam logic [2:0] SRC_LAST = 3'd7;

   // Starting carry states for the two wrap-carry guesses.
   localparam logic [2:0] START_STATE0 = 3'd4;
   localparam logic [2:0] START_STATE1 = 3'd6;

   // Position classes: x bit below, above or at the wrap point.
   typedef enum logic [1:0] {
      CLS_BELOW,
      CLS_ABOVE,
      CLS_EQUAL
   } rsh_cls_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_STEP,
      ST_SUM,
      ST_DONE
   } rsh_state_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic       init;
      logic       step;
      logic       last_src;
      logic       sum;
      logic       load_out;
      logic [2:0] src;
   } rsh_ctl_type;

   typedef logic [COUNT_W-1:0] rsh_count_type;

   // Number of (a, x) bit choices that lead from one source state to each
   // destination state; at most four.
   typedef logic [NUM_STATES-1:0][2:0] rsh_mult_type;

   // Transition multiplicities out of one source carry state at one bit.
   function automatic rsh_mult_type rsh_trans(input logic [2:0]  src,
                                              input rsh_cls_type cls,
                                              input logic        da,
                                              input logic        dx,
                                              input logic        db);
      rsh_mult_type m;
      logic         s1;
      logic         s2;
      logic         a1;
      logic         x1;
      logic         a2;
      logic         x2;
      logic         xv1;
      logic         xv2;
      logic         s1o;
      logic         s2o;
      logic [2:0]   tp;
      logic [2:0]   v;
      m  = '0;
      s1 = src[0];
      s2 = (cls == CLS_EQUAL) ? 1'b0 : src[1];
      for (int k = 0; k < 4; k++) begin
         a1  = k[1];
         x1  = k[0];
         a2  = a1 ^ da ^ s1;
         x2  = x1 ^ dx ^ s2;
         s1o = (a1 & da) | (a1 & s1) | (da & s1);
         s2o = (x1 & dx) | (x1 & s2) | (dx & s2);
         xv1 = (cls == CLS_BELOW) ? x1 : 1'b0;
         xv2 = (cls == CLS_BELOW) ? x2 : 1'b0;
         // Output difference bit plus borrow, offset to stay non-negative.
         tp  = {2'b00, a2 ^ xv2} + {2'b00, src[2]} + 3'd1 - {2'b00, a1 ^ xv1};
         v   = {tp[1], s2o, s1o};
         if (tp[0] == db) begin
            m[v] = m[v] + 3'd1;
         end
      end
      return m;
   endfunction

   // Multiply a count by a small multiplicity with shifts and one add.
   function automatic rsh_count_type rsh_scale(input rsh_count_type x,
                                               input logic [2:0]    m);
      rsh_count_type r;
      case (m)
         3'd1:    r = x;
         3'd2:    r = {x[COUNT_W-2:0], 1'b0};
         3'd3:    r = x + {x[COUNT_W-2:0], 1'b0};
         3'd4:    r = {x[COUNT_W-3:0], 2'b00};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/rsh_seq.sv @@
module rsh_seq
   import rsh_pkg::*;
#(
   parameter int WORD_BITS = 16,
   localparam int POS_W = $clog2(WORD_BITS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsh_ctl_type      ctl,
   output logic [POS_W-1:0] pos
);

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORD_BITS - 1);

   rsh_state_type    state_ff;
   rsh_state_type    state_in;
   logic [2:0]       src_ff;
   logic [2:0]       src_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk source states within a bit position, then positions, then the sum.
   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ctl          = '0;
      ctl.src      = src_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            ctl.init = 1'b1;
            src_in   = '0;
            pos_in   = '0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            ctl.step     = 1'b1;
            ctl.last_src = (src_ff == SRC_LAST);
            src_in       = src_ff + 3'd1;
            if (src_ff == SRC_LAST) begin
               if (pos_ff == POS_LAST) begin
                  pos_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         ST_SUM: begin
            ctl.sum = 1'b1;
            src_in  = src_ff + 3'd1;
            if (src_ff == SRC_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Wait until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign pos       = pos_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_INIT))
      else $error("accepted word did not start the sequence");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while still pending");

   a_sum_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (pos_ff == '0))
      else $error("bit position not cleared before the final sum");

   a_step_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && src_ff == SRC_LAST && pos_ff == POS_LAST)
      |=> (state_ff == ST_SUM))
      else $error("last bit position did not lead to the final sum");
`endif

endmodule

@@ hdl/rsh_datapath.sv @@
module rsh_datapath
   import rsh_pkg::*;
#(
   parameter int WORD_BITS = 16,
   localparam int POS_W = $clog2(WORD_BITS)
) (
   input  logic                 clock,
   input  rsh_ctl_type          ctl,
   input  logic [POS_W-1:0]     pos,
   input  logic [DIFF_BITS-1:0] diff_a,
   input  logic [DIFF_BITS-1:0] diff_x,
   input  logic [DIFF_BITS-1:0] diff_b,
   input  logic [SHIFT_W-1:0]   shift_amount,
   output rsh_count_type        pair_count
);

   localparam logic [SEL_W-1:0] N_SEL = SEL_W'(WORD_BITS);

   // Current carry vectors and the next vectors being accumulated, per guess.
   rsh_count_type cur_ff [2][NUM_STATES];
   rsh_count_type acc_ff [2][NUM_STATES];
   rsh_count_type acc_sum [2][NUM_STATES];
   rsh_count_type total_ff;
   rsh_count_type count_ff;

   logic [SEL_W-1:0] pos_sel;
   logic [SEL_W-1:0] sum_sel;
   logic [SEL_W-1:0] xpos;
   logic             wrap;
   rsh_cls_type      cls;
   logic             dab;
   logic             dxb;
   logic             dbb;
   rsh_mult_type     mult;
   rsh_count_type    sel0;
   rsh_count_type    sel1;

   // Position class and the difference bits seen at this position.
   always_comb begin
      pos_sel = SEL_W'(pos);
      sum_sel = pos_sel + SEL_W'(shift_amount);
      xpos    = (sum_sel >= N_SEL) ? sum_sel - N_SEL : sum_sel;
      if (sum_sel < N_SEL) begin
         cls = CLS_BELOW;
      end else if (sum_sel > N_SEL) begin
         cls = CLS_ABOVE;
      end else begin
         cls = CLS_EQUAL;
      end
      dab  = (pos_sel < SEL_W'(DIFF_BITS)) ? diff_a[pos_sel[DIFF_IDX_W-1:0]] : 1'b0;
      dbb  = (pos_sel < SEL_W'(DIFF_BITS)) ? diff_b[pos_sel[DIFF_IDX_W-1:0]] : 1'b0;
      dxb  = (xpos < SEL_W'(DIFF_BITS)) ? diff_x[xpos[DIFF_IDX_W-1:0]] : 1'b0;
      wrap = (shift_amount != '0) && (SEL_W'(shift_amount) < N_SEL);
   end

   // Shared transition unit: spread one source state into all destinations.
   always_comb begin
      mult = rsh_trans(ctl.src, cls, dab, dxb, dbb);
      for (int g = 0; g < 2; g++) begin
         for (int v = 0; v < NUM_STATES; v++) begin
            acc_sum[g][v] = acc_ff[g][v] + rsh_scale(cur_ff[g][ctl.src], mult[v]);
         end
      end
   end

   // Final sum keeps states whose x carry matches the guess; without a wrap it keeps every state of guess 0.
   always_comb begin
      sel0 = (!wrap || !ctl.src[1]) ? cur_ff[0][ctl.src] : '0;
      sel1 = (wrap && ctl.src[1]) ? cur_ff[1][ctl.src] : '0;
   end

   // Vector, accumulator and total registers.
   always_ff @(posedge clock) begin
      if (ctl.init) begin
         // Each guess starts from its own carry state; the second only when wrapping.
         for (int v = 0; v < NUM_STATES; v++) begin
            cur_ff[0][v] <= (v == int'(START_STATE0)) ? COUNT_W'(1) : '0;
            cur_ff[1][v] <= (wrap && (v == int'(START_STATE1))) ? COUNT_W'(1) : '0;
            acc_ff[0][v] <= '0;
            acc_ff[1][v] <= '0;
         end
         total_ff <= '0;
      end else if (ctl.step) begin
         for (int g = 0; g < 2; g++) begin
            for (int v = 0; v < NUM_STATES; v++) begin
               if (ctl.last_src) begin
                  cur_ff[g][v] <= acc_sum[g][v];
                  acc_ff[g][v] <= '0;
               end else begin
                  acc_ff[g][v] <= acc_sum[g][v];
               end
            end
         end
      end else if (ctl.sum) begin
         total_ff <= total_ff + sel0 + sel1;
      end
      if (ctl.load_out) begin
         count_ff <= total_ff;
      end
   end

   assign pair_count = count_ff;

endmodule

@@ hdl/rsh_xor_additive_diff_probability.sv @@
// Channel   Direction  Ports                                        Word
// request   in         req_valid, req_ready, req_diff_a/x/b,        one query
//                      req_shift_amount
// response  out        rsp_valid, rsp_ready, rsp_pair_count         one pair count
//
// From acceptance to rsp_valid a query passes through a setup step, the bit positions
// (one source carry state per cycle for both guesses), the final sum over the carry
// states and the load of the output register.
// req_ready is high only while idle, so a new query is accepted only after the last
// one has loaded its result; a result still waiting for rsp_ready stalls the next load.
// Reset is synchronous and active high and clears only the control state.
module rsh_xor_additive_diff_probability
   import rsh_pkg::*;
#(
   parameter int WORD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DIFF_BITS-1:0] req_diff_a,
   input  logic [DIFF_BITS-1:0] req_diff_x,
   input  logic [DIFF_BITS-1:0] req_diff_b,
   input  logic [SHIFT_W-1:0]   req_shift_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COUNT_W-1:0]   rsp_pair_count
);

   localparam int POS_W = $clog2(WORD_BITS);

   rsh_ctl_type          ctl;
   logic [POS_W-1:0]     pos;
   logic [DIFF_BITS-1:0] diff_a_ff;
   logic [DIFF_BITS-1:0] diff_x_ff;
   logic [DIFF_BITS-1:0] diff_b_ff;
   logic [SHIFT_W-1:0]   shift_amount_ff;

   // Hold the query word for the whole computation.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         diff_a_ff       <= req_diff_a;
         diff_x_ff       <= req_diff_x;
         diff_b_ff       <= req_diff_b;
         shift_amount_ff <= req_shift_amount;
      end
   end

   rsh_seq #(
      .WORD_BITS(WORD_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .pos       (pos)
   );

   rsh_datapath #(
      .WORD_BITS(WORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .ctl          (ctl),
      .pos          (pos),
      .diff_a       (diff_a_ff),
      .diff_x       (diff_x_ff),
      .diff_b       (diff_b_ff),
      .shift_amount (shift_amount_ff),
      .pair_count   (rsp_pair_count)
   );

endmodule

@@ sim/tb_rsh_xor_additive_diff_probability.sv @@
module tb_rsh_xor_additive_diff_probability
   import rsh_pkg::*;
();

   localparam int WORD_BITS    = 16;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 6;
   // Cycles from acceptance of a query to its pair count.
   localparam int QUERY_CYCLES = 8 * WORD_BITS + 10;
   localparam int NUM_DIRECTED = 22;
   localparam int RANDOM_WORDS = 1080;
   localparam int NUM_WORDS    = NUM_DIRECTED + RANDOM_WORDS;
   localparam int MAX_CYCLES   = 1_000_000;
   localparam int REPORT_LIMIT = 10;
   localparam rsh_count_type ALL_PAIRS = rsh_count_type'(64'd1 << (2 * WORD_BITS));

   // One query word together with the pair count that it should produce.
   typedef struct packed {
      logic [DIFF_BITS-1:0] diff_a;
      logic [DIFF_BITS-1:0] diff_x;
      logic [DIFF_BITS-1:0] diff_b;
      logic [SHIFT_W-1:0]   shift;
      logic                 known;
      rsh_count_type        count;
   } query_row_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [DIFF_BITS-1:0] req_diff_a       = '0;
   logic [DIFF_BITS-1:0] req_diff_x       = '0;
   logic [DIFF_BITS-1:0] req_diff_b       = '0;
   logic [SHIFT_W-1:0]   req_shift_amount = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [COUNT_W-1:0]   rsp_pair_count;

   // Known count of the word on the request port, for rows that carry one.
   logic                 row_known        = 1'b0;
   rsh_count_type        row_count        = '0;

   logic                 steady_run       = 1'b0;
   int unsigned          done_count       = 0;
   int unsigned          error_count      = 0;
   int unsigned          cycle_count      = 0;
   query_row_type        expected_counts_q[$];

   always #(CLK_PERIOD / 2) clock = ~clock;

   rsh_xor_additive_diff_probability #(
      .WORD_BITS(WORD_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_diff_a      (req_diff_a),
      .req_diff_x      (req_diff_x),
      .req_diff_b      (req_diff_b),
      .req_shift_amount(req_shift_amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pair_count  (rsp_pair_count)
   );

   // Directed words. Counts are typed in where they are obvious: with no input
   // difference the output difference is always zero, and adding the top bit to a, or to x
   // when unshifted, commutes with the XOR. All other rows go through the predictor.
   query_row_type directed_rows [NUM_DIRECTED] = '{
      '{16'h0000, 16'h0000, 16'h0000, 4'd0,  1'b1, ALL_PAIRS},
      '{16'h0000, 16'h0000, 16'h0000, 4'd15, 1'b1, ALL_PAIRS},
      '{16'h0000, 16'h0000, 16'h0000, 4'd1,  1'b1, ALL_PAIRS},
      '{16'h0000, 16'h0000, 16'h0001, 4'd0,  1'b1, 33'd0},
      '{16'h0000, 16'h0000, 16'hFFFF, 4'd7,  1'b1, 33'd0},
      '{16'h0000, 16'h0000, 16'h8000, 4'd15, 1'b1, 33'd0},
      '{16'h8000, 16'h0000, 16'h8000, 4'd3,  1'b1, ALL_PAIRS},
      '{16'h0000, 16'h8000, 16'h0000, 4'd0,  1'b1, 33'd0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0,  1'b0, 33'd0},
      '{16'hFFFF, 16'h0000, 16'hFFFF, 4'd0,  1'b0, 33'd0},
      '{16'h0000, 16'hFFFF, 16'h0000, 4'd15, 1'b0, 33'd0},
      '{16'h8000, 16'h8000, 16'h0000, 4'd0,  1'b0, 33'd0},
      '{16'h0000, 16'h0001, 16'h0000, 4'd15, 1'b0, 33'd0},
      '{16'h0001, 16'h0001, 16'h0002, 4'd0,  1'b0, 33'd0},
      '{16'h0001, 16'h0000, 16'h0001, 4'd1,  1'b0, 33'd0},
      '{16'hAAAA, 16'h5555, 16'hFFFF, 4'd8,  1'b0, 33'd0},
      '{16'h5555, 16'hAAAA, 16'h0000, 4'd4,  1'b0, 33'd0},
      '{16'h0000, 16'hFFFF, 16'hFFFF, 4'd1,  1'b0, 33'd0},
      '{16'h1234, 16'h8765, 16'hABCD, 4'd15, 1'b0, 33'd0},
      '{16'hFFFF, 16'h0001, 16'h0000, 4'd14, 1'b0, 33'd0},
      '{16'h0001, 16'h0000, 16'h0001, 4'd0,  1'b0, 33'd0},
      '{16'h0000, 16'hFFFF, 16'h0001, 4'd15, 1'b0, 33'd0}
   };

   // Exact pair count by an S-function walk over a carry vector of
   // {output borrow, x carry, a carry}. The x bits are visited from bit r upward
   // and wrap around, so the carry into x bit r is guessed both ways and only
   // paths that end with the same x carry are counted.
   function automatic rsh_count_type count_matching_pairs(input logic [DIFF_BITS-1:0] da,
                                                          input logic [DIFF_BITS-1:0] dx,
                                                          input logic [DIFF_BITS-1:0] db,
                                                          input logic [SHIFT_W-1:0]   r);
      logic [63:0] ways [2][NUM_STATES];
      logic [63:0] next_ways [NUM_STATES];
      logic [63:0] total;
      logic        wraps;
      int          guesses;
      int          reach;
      int          tp;
      rsh_cls_type cls;
      logic        bit_a;
      logic        bit_x;
      logic        bit_b;
      logic        carry_a;
      logic        carry_x;
      logic        a_new;
      logic        x_new;
      logic        xs_old;
      logic        xs_new;
      logic        cout_a;
      logic        cout_x;
      logic [2:0]  dst;
      wraps   = (r != '0) && (int'(r) < WORD_BITS);
      guesses = wraps ? 2 : 1;
      for (int g = 0; g < 2; g++) begin
         for (int s = 0; s < NUM_STATES; s++) begin
            ways[g][s] = '0;
         end
      end
      ways[0][START_STATE0] = 64'd1;
      if (wraps) begin
         ways[1][START_STATE1] = 64'd1;
      end
      for (int pos = 0; pos < WORD_BITS; pos++) begin
         reach = pos + int'(r);
         cls   = (reach < WORD_BITS) ? CLS_BELOW
                                     : ((reach > WORD_BITS) ? CLS_ABOVE : CLS_EQUAL);
         bit_a = da[pos];
         bit_x = dx[reach % WORD_BITS];
         bit_b = db[pos];
         for (int g = 0; g < guesses; g++) begin
            for (int s = 0; s < NUM_STATES; s++) begin
               next_ways[s] = '0;
            end
            for (int s = 0; s < NUM_STATES; s++) begin
               carry_a = s[0];
               // At the wrap point the x carry restarts at zero.
               carry_x = (cls == CLS_EQUAL) ? 1'b0 : s[1];
               for (int k = 0; k < 4; k++) begin
                  a_new  = k[1] ^ bit_a ^ carry_a;
                  x_new  = k[0] ^ bit_x ^ carry_x;
                  cout_a = (int'(k[1]) + int'(bit_a) + int'(carry_a)) >= 2;
                  cout_x = (int'(k[0]) + int'(bit_x) + int'(carry_x)) >= 2;
                  // Shifted-out x bits contribute zeros to the output.
                  xs_old = (cls == CLS_BELOW) ? k[0] : 1'b0;
                  xs_new = (cls == CLS_BELOW) ? x_new : 1'b0;
                  // Output difference bit with borrow, offset by one, never negative.
                  tp = int'(a_new ^ xs_new) - int'(k[1] ^ xs_old) + int'(s[2]) + 1;
                  if (tp[0] == bit_b) begin
                     dst            = {tp[1], cout_x, cout_a};
                     next_ways[dst] = next_ways[dst] + ways[g][s];
                  end
               end
            end
            for (int s = 0; s < NUM_STATES; s++) begin
               ways[g][s] = next_ways[s];
            end
         end
      end
      total = '0;
      for (int g = 0; g < guesses; g++) begin
         for (int s = 0; s < NUM_STATES; s++) begin
            if (!wraps || (s[1] == g[0])) begin
               total = total + ways[g][s];
            end
         end
      end
      return total[COUNT_W-1:0];
   endfunction

   // Random query. Most output differences are aimed near the likely ones so
   // that many counts are nonzero; the rest are fully random or tiny.
   function automatic query_row_type random_query();
      query_row_type q;
      logic [DIFF_BITS-1:0] shifted;
      q       = '0;
      q.shift = SHIFT_W'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            q.diff_a = DIFF_BITS'($urandom);
            q.diff_x = DIFF_BITS'($urandom);
            q.diff_b = DIFF_BITS'($urandom);
         end
         3, 4, 5, 6: begin
            if ($urandom_range(0, 1) == 0) begin
               q.diff_a = DIFF_BITS'($urandom & $urandom & $urandom);
               q.diff_x = DIFF_BITS'($urandom & $urandom & $urandom);
            end else begin
               q.diff_a = DIFF_BITS'($urandom);
               q.diff_x = DIFF_BITS'($urandom);
            end
            shifted  = q.diff_x >> q.shift;
            q.diff_b = q.diff_a + shifted;
         end
         7, 8: begin
            q.diff_a = DIFF_BITS'($urandom & $urandom);
            q.diff_x = DIFF_BITS'($urandom & $urandom);
            shifted  = q.diff_x >> q.shift;
            q.diff_b = q.diff_a ^ shifted ^ (16'h1 << $urandom_range(0, 15));
         end
         default: begin
            q.diff_a = DIFF_BITS'($urandom_range(0, 3));
            q.diff_x = DIFF_BITS'($urandom_range(0, 3));
            q.diff_b = DIFF_BITS'($urandom_range(0, 7));
         end
      endcase
      return q;
   endfunction

   task automatic report_error(input string what, input query_row_type q,
                               input rsh_count_type actual_count);
      if (error_count < REPORT_LIMIT) begin
         $display("%s: da=%h dx=%h db=%h r=%0d expected %0d, got %0d", what, q.diff_a,
                  q.diff_x, q.diff_b, q.shift, q.count, actual_count);
      end
      error_count++;
   endtask

   // Query sender: directed words, then random ones, with random gaps, a steady
   // stretch without gaps, and two holds until every pending word has returned.
   initial begin
      query_row_type row;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         row = (i < NUM_DIRECTED) ? directed_rows[i] : random_query();
         steady_run <= (i >= 500) && (i < 700);
         if ((i == NUM_DIRECTED) || (i == 850)) begin
            if (done_count != i) begin
               req_valid <= 1'b0;
               while (done_count != i) @(posedge clock);
            end
         end else if (!((i >= 500) && (i < 700)) && ($urandom_range(0, 99) < 10)) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, QUERY_CYCLES + 20)) @(posedge clock);
         end
         req_valid        <= 1'b1;
         req_diff_a       <= row.diff_a;
         req_diff_x       <= row.diff_x;
         req_diff_b       <= row.diff_b;
         req_shift_amount <= row.shift;
         row_known        <= row.known;
         row_count        <= row.count;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
      while (done_count != NUM_WORDS) @(posedge clock);
      repeat (QUERY_CYCLES + 10) @(posedge clock);
      if (expected_counts_q.size() != 0) begin
         $display("%0d pair counts never returned", expected_counts_q.size());
      end
      if ((error_count == 0) && (expected_counts_q.size() == 0)) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Records each accepted query, checks each returned pair count against the
   // oldest expectation, and stalls the response side at random.
   always @(posedge clock) begin
      query_row_type q;
      query_row_type oldest;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            q.diff_a = req_diff_a;
            q.diff_x = req_diff_x;
            q.diff_b = req_diff_b;
            q.shift  = req_shift_amount;
            q.known  = row_known;
            q.count  = row_known ? row_count
                                 : count_matching_pairs(req_diff_a, req_diff_x,
                                                        req_diff_b, req_shift_amount);
            expected_counts_q.push_back(q);
         end
         if (rsp_valid && rsp_ready) begin
            done_count <= done_count + 1;
            if (expected_counts_q.size() == 0) begin
               report_error("unexpected pair count", '0, rsp_pair_count);
            end else begin
               oldest = expected_counts_q.pop_front();
               if (rsp_pair_count !== oldest.count) begin
                  report_error("pair count mismatch", oldest, rsp_pair_count);
               end
            end
         end
         rsp_ready <= steady_run || ($urandom_range(0, 99) >= 10);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == MAX_CYCLES);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
